FILE: rtl/brf_pkg.sv
// shared types, codes and arithmetic helpers for the bisection root finder
package brf_pkg;

  // outcome codes carried on the status field
  localparam logic [1:0] ST_EXACT     = 2'd0;
  localparam logic [1:0] ST_BRACKET   = 2'd1;
  localparam logic [1:0] ST_NO_CHANGE = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  localparam logic signed [63:0] INT64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_DRAIN,
    S_FIN,
    S_SUM1,
    S_SUM2,
    S_POST,
    S_MID,
    S_STEP,
    S_PICK,
    S_DONE
  } state_t;

  // which point the running evaluation belongs to
  typedef enum logic [1:0] {
    PH_LOWER,
    PH_UPPER,
    PH_MID
  } phase_t;

  // product being formed inside one evaluation
  typedef enum logic [1:0] {
    OP_SQ,
    OP_QUAD,
    OP_FIFTH
  } op_t;

  // one finished result beat
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] root;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic [5:0]         steps;
  } result_t;

  // signed 64-bit add clamped to the signed range
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? INT64_MIN : INT64_MAX;
    end
    return s;
  endfunction

  // absolute value as an unsigned 64-bit word
  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

endpackage

FILE: rtl/bisection_root_finder.sv
// bisection root finder for f(x) = x^5 + x + 1 on a shared 32x32 multiplier
//
// Input channel (in_valid / in_stall) takes one beat holding the interval ends
// lower_end and upper_end in signed fixed point with FRAC_BITS fraction bits.
// Output channel (out_valid / out_stall) returns one beat per input beat with
// status, root_estimate, final_lower, final_upper and steps_taken.
// The tolerance register is written through cfg_write / cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Each evaluation of f uses seven 32x32 partial products on the one multiplier
// (1 for x^2, 4 for x^4, 2 for x^5), with a load, a drain and a rounding and
// clamping step per product, then two clamped adds and a dispatch step.
// Invalid arguments go straight to the result beat; an exact root at the lower
// end ends after one evaluation, one at the upper end or no sign change after two.
// Then a midpoint is evaluated before each halving step, until the width is within
// tolerance, a midpoint is a root or the step cap (32 by default) is reached.
// One item is worked on at a time; in_stall stays high from acceptance until
// the result beat is taken.
// Reset returns the sequencer to idle, drops out_valid and sets tolerance to 1.
// While out_stall is high the result beat holds steady and no new item enters.
module bisection_root_finder #(
  parameter int MAX_STEPS = 32,
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] lower_end,
  input  logic signed [31:0] upper_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] root_estimate,
  output logic signed [31:0] final_lower,
  output logic signed [31:0] final_upper,
  output logic [5:0]         steps_taken
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(MAX_STEPS);
  localparam logic [6:0] STEPS_OUT_MAX = 7'd63;
  localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;

  brf_pkg::state_t state, state_next;
  brf_pkg::phase_t phase;
  brf_pkg::op_t    op;

  logic [31:0]        tolerance;
  logic signed [31:0] lo, hi, px;
  logic signed [63:0] flo, fhi, fmid, fval, fsum;
  logic signed [63:0] x2, x4, x5;
  logic [STEP_W-1:0]  steps;

  // multiplier datapath
  logic [63:0]  mag_a, mag_b;
  logic         neg;
  logic [1:0]   cnt, last_cnt;
  logic [63:0]  pp_reg;
  logic [1:0]   pp_sh;
  logic         pp_vld;
  logic [127:0] acc;

  brf_pkg::result_t res, res_next;
  logic             res_load;

  logic accept;
  assign accept = in_valid && !in_stall;

  assign in_stall      = (state != brf_pkg::S_IDLE);
  assign out_valid     = (state == brf_pkg::S_DONE);
  assign status        = res.status;
  assign root_estimate = res.root;
  assign final_lower   = res.lower;
  assign final_upper   = res.upper;
  assign steps_taken   = res.steps;

  // evaluation point widened to 64 bits
  logic signed [63:0] px_ext;
  assign px_ext = {{32{px[31]}}, px};

  // operand selection for the next product
  logic [63:0] src_a, src_b;
  logic [1:0]  src_last;
  always_comb begin
    case (op)
      brf_pkg::OP_SQ: begin
        src_a    = px_ext;
        src_b    = px_ext;
        src_last = 2'd0;
      end
      brf_pkg::OP_QUAD: begin
        src_a    = x2;
        src_b    = x2;
        src_last = 2'd3;
      end
      default: begin
        src_a    = x4;
        src_b    = px_ext;
        src_last = 2'd1;
      end
    endcase
  end

  // partial product operands, low or high halves
  logic [31:0] half_a, half_b;
  assign half_a = cnt[0] ? mag_a[63:32] : mag_a[31:0];
  assign half_b = cnt[1] ? mag_b[63:32] : mag_b[31:0];

  // partial product aligned to its weight
  logic [127:0] pp_ext, pp_aligned;
  assign pp_ext = {64'd0, pp_reg};
  always_comb begin
    case (pp_sh)
      2'd0:    pp_aligned = pp_ext;
      2'd1:    pp_aligned = pp_ext << 32;
      default: pp_aligned = pp_ext << 64;
    endcase
  end

  // floor of the product over 2^FRAC_BITS, clamped to 64 bits
  logic [127:0]       q_full;
  logic               rnd, ovf;
  logic [63:0]        limit;
  logic signed [63:0] prod_val;
  always_comb begin
    rnd      = neg && (acc[FRAC_BITS-1:0] != '0);
    q_full   = (acc >> FRAC_BITS) + 128'(rnd);
    limit    = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    ovf      = (q_full[127:64] != 64'd0) || (q_full[63:0] > limit);
    if (ovf) begin
      prod_val = neg ? brf_pkg::INT64_MIN : brf_pkg::INT64_MAX;
    end else begin
      prod_val = neg ? (64'd0 - q_full[63:0]) : q_full[63:0];
    end
  end

  // interval width and midpoint
  logic signed [32:0] diff;
  logic signed [31:0] mid;
  assign diff = {hi[31], hi} - {lo[31], lo};
  assign mid  = lo + 32'(diff >>> 1);

  logic loop_go, invalid_args, same_lo_mid;
  assign loop_go      = (diff[31:0] > tolerance) && (steps < STEP_CAP);
  assign invalid_args = (lower_end >= upper_end) || (tolerance == 32'd0);
  assign same_lo_mid  = (flo[63] == fmid[63]);

  // halving count as reported, saturated to six bits
  logic [6:0] steps_wide;
  logic [5:0] steps_sat;
  assign steps_wide = 7'(steps);
  assign steps_sat  = (steps_wide > STEPS_OUT_MAX) ? 6'd63 : steps_wide[5:0];

  // best of the three points by smallest |f|
  logic [63:0] alo, ahi, amid;
  assign alo  = brf_pkg::mag64(flo);
  assign ahi  = brf_pkg::mag64(fhi);
  assign amid = brf_pkg::mag64(fmid);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and result beat
  always_comb begin
    state_next = state;
    res_load   = 1'b0;
    res_next   = res;
    case (state)
      brf_pkg::S_IDLE: begin
        if (accept) begin
          if (invalid_args) begin
            res_load   = 1'b1;
            res_next   = '{brf_pkg::ST_INVALID, 32'sd0, lower_end, upper_end, 6'd0};
            state_next = brf_pkg::S_DONE;
          end else begin
            state_next = brf_pkg::S_LOAD;
          end
        end
      end
      brf_pkg::S_LOAD:  state_next = brf_pkg::S_MUL;
      brf_pkg::S_MUL:   state_next = (cnt == last_cnt) ? brf_pkg::S_DRAIN : brf_pkg::S_MUL;
      brf_pkg::S_DRAIN: state_next = brf_pkg::S_FIN;
      brf_pkg::S_FIN:   state_next = (op == brf_pkg::OP_FIFTH) ? brf_pkg::S_SUM1
                                                                : brf_pkg::S_LOAD;
      brf_pkg::S_SUM1:  state_next = brf_pkg::S_SUM2;
      brf_pkg::S_SUM2:  state_next = brf_pkg::S_POST;
      brf_pkg::S_POST: begin
        case (phase)
          brf_pkg::PH_LOWER: begin
            if (fval == 64'sd0) begin
              res_load   = 1'b1;
              res_next   = '{brf_pkg::ST_EXACT, lo, lo, hi, 6'd0};
              state_next = brf_pkg::S_DONE;
            end else begin
              state_next = brf_pkg::S_LOAD;
            end
          end
          brf_pkg::PH_UPPER: begin
            if (fval == 64'sd0) begin
              res_load   = 1'b1;
              res_next   = '{brf_pkg::ST_EXACT, hi, lo, hi, 6'd0};
              state_next = brf_pkg::S_DONE;
            end else if (flo[63] == fval[63]) begin
              res_load   = 1'b1;
              res_next   = '{brf_pkg::ST_NO_CHANGE, 32'sd0, lo, hi, 6'd0};
              state_next = brf_pkg::S_DONE;
            end else begin
              state_next = brf_pkg::S_MID;
            end
          end
          default: state_next = brf_pkg::S_STEP;
        endcase
      end
      brf_pkg::S_MID: state_next = brf_pkg::S_LOAD;
      brf_pkg::S_STEP: begin
        if (!loop_go) begin
          state_next = brf_pkg::S_PICK;
        end else if (fmid == 64'sd0) begin
          res_load   = 1'b1;
          res_next   = '{brf_pkg::ST_EXACT, px, lo, hi, steps_sat};
          state_next = brf_pkg::S_DONE;
        end else begin
          state_next = brf_pkg::S_MID;
        end
      end
      brf_pkg::S_PICK: begin
        res_load = 1'b1;
        if (alo <= amid && alo <= ahi) begin
          res_next = '{brf_pkg::ST_BRACKET, lo, lo, hi, steps_sat};
        end else if (amid <= alo && amid <= ahi) begin
          res_next = '{brf_pkg::ST_BRACKET, px, lo, hi, steps_sat};
        end else begin
          res_next = '{brf_pkg::ST_BRACKET, hi, lo, hi, steps_sat};
        end
        state_next = brf_pkg::S_DONE;
      end
      brf_pkg::S_DONE: begin
        if (!out_stall) begin
          state_next = brf_pkg::S_IDLE;
        end
      end
      default: state_next = brf_pkg::S_IDLE;
    endcase
  end

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= 32'd1;
    end else if (cfg_write) begin
      tolerance <= cfg_data;
    end
  end

  // partial product valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pp_vld <= 1'b0;
    end else begin
      pp_vld <= (state == brf_pkg::S_MUL);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  // multiplier: one partial product a cycle, accumulated in the cycle after
  always_ff @(posedge clk) begin
    if (state == brf_pkg::S_LOAD) begin
      mag_a    <= brf_pkg::mag64(src_a);
      mag_b    <= brf_pkg::mag64(src_b);
      neg      <= src_a[63] ^ src_b[63];
      last_cnt <= src_last;
      cnt      <= 2'd0;
      acc      <= '0;
    end else begin
      if (pp_vld) begin
        acc <= acc + pp_aligned;
      end
      if (state == brf_pkg::S_MUL) begin
        pp_reg <= half_a * half_b;
        pp_sh  <= 2'(cnt[0]) + 2'(cnt[1]);
        cnt    <= cnt + 2'd1;
      end
    end
  end

  // evaluation and bisection registers
  always_ff @(posedge clk) begin
    case (state)
      brf_pkg::S_IDLE: begin
        if (accept) begin
          lo    <= lower_end;
          hi    <= upper_end;
          px    <= lower_end;
          steps <= '0;
          phase <= brf_pkg::PH_LOWER;
          op    <= brf_pkg::OP_SQ;
        end
      end
      brf_pkg::S_FIN: begin
        case (op)
          brf_pkg::OP_SQ: begin
            x2 <= prod_val;
            op <= brf_pkg::OP_QUAD;
          end
          brf_pkg::OP_QUAD: begin
            x4 <= prod_val;
            op <= brf_pkg::OP_FIFTH;
          end
          default: x5 <= prod_val;
        endcase
      end
      brf_pkg::S_SUM1: fsum <= brf_pkg::sat_add(x5, px_ext);
      brf_pkg::S_SUM2: fval <= brf_pkg::sat_add(fsum, ONE_FX);
      brf_pkg::S_POST: begin
        case (phase)
          brf_pkg::PH_LOWER: begin
            flo   <= fval;
            px    <= hi;
            phase <= brf_pkg::PH_UPPER;
            op    <= brf_pkg::OP_SQ;
          end
          brf_pkg::PH_UPPER: fhi  <= fval;
          default:           fmid <= fval;
        endcase
      end
      brf_pkg::S_MID: begin
        px    <= mid;
        phase <= brf_pkg::PH_MID;
        op    <= brf_pkg::OP_SQ;
      end
      brf_pkg::S_STEP: begin
        if (loop_go && fmid != 64'sd0) begin
          if (same_lo_mid) begin
            lo  <= px;
            flo <= fmid;
          end else begin
            hi  <= px;
            fhi <= fmid;
          end
          steps <= steps + STEP_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // an accepted item always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != brf_pkg::S_IDLE)
    else $error("item accepted but sequencer stayed idle");

  // early outcomes carry no estimate and no halvings
  a_early_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == brf_pkg::ST_INVALID || status == brf_pkg::ST_NO_CHANGE)
      |-> root_estimate == 32'sd0 && steps_taken == 6'd0)
    else $error("early outcome with nonzero estimate or step count");

  // a searched interval stays ordered
  a_interval_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != brf_pkg::ST_INVALID |-> final_lower < final_upper)
    else $error("final interval out of order");

  // loop check never sees a broken bracket or an overrun count
  a_step_bounds: assert property (@(posedge clk) disable iff (rst)
    state == brf_pkg::S_STEP |-> lo < hi && steps <= STEP_CAP)
    else $error("bisection bracket or step count out of range");

  // partial products only come from the multiply state
  a_pp_source: assert property (@(posedge clk) disable iff (rst)
    pp_vld |-> $past(state) == brf_pkg::S_MUL)
    else $error("partial product valid outside multiply sequence");

endmodule

FILE: tb/bisection_root_finder_test.sv
// self-checking testbench for the bisection root finder: directed table, then random intervals
`timescale 1ns / 100ps

module bisection_root_finder_test;

  localparam int MAX_STEPS = 32;
  localparam int FRAC_BITS = 28;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int TAIL_CYCLES = 200;
  localparam int ITEMS_PER_SETTING = 70;

  // one expected result beat
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] root;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic [5:0]         steps;
  } bisect_out_t;

  // one row of the directed table
  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
    bit                 typed;
    bisect_out_t        want;
  } probe_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] lower_end = '0;
  logic signed [31:0] upper_end = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] root_estimate;
  logic signed [31:0] final_lower;
  logic signed [31:0] final_upper;
  logic [5:0]         steps_taken;

  bisect_out_t        pending_results[$];
  bisect_out_t        due;
  logic [31:0]        tolerance_now = 32'd1;
  logic signed [31:0] root_x;
  int                 errors = 0;
  int                 cycles = 0;
  int                 stall_run = 0;

  bisection_root_finder #(
    .MAX_STEPS(MAX_STEPS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .lower_end(lower_end),
    .upper_end(upper_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .root_estimate(root_estimate),
    .final_lower(final_lower),
    .final_upper(final_upper),
    .steps_taken(steps_taken)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // fixed-point product, floor of the exact value, clamped to 64 bits
  function automatic logic signed [63:0] qmul(input logic signed [63:0] x,
                                              input logic signed [63:0] y);
    logic signed [127:0] xw, yw, wide;
    xw = x;
    yw = y;
    wide = (xw * yw) >>> FRAC_BITS;
    if (wide > brf_pkg::INT64_MAX) return brf_pkg::INT64_MAX;
    if (wide < brf_pkg::INT64_MIN) return brf_pkg::INT64_MIN;
    return wide[63:0];
  endfunction

  // 64-bit add clamped to the signed range
  function automatic logic signed [63:0] clamp_add(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
    logic signed [64:0] s;
    s = x + y;
    if (s > brf_pkg::INT64_MAX) return brf_pkg::INT64_MAX;
    if (s < brf_pkg::INT64_MIN) return brf_pkg::INT64_MIN;
    return s[63:0];
  endfunction

  // f(x) = x^5 + x + 1 in fixed point
  function automatic logic signed [63:0] poly_at(input logic signed [63:0] x);
    logic signed [63:0] x2, x4, x5;
    x2 = qmul(x, x);
    x4 = qmul(x2, x2);
    x5 = qmul(x4, x);
    return clamp_add(clamp_add(x5, x), 64'sd1 <<< FRAC_BITS);
  endfunction

  // full bisection search for one interval
  function automatic bisect_out_t solve_bisection(input logic signed [31:0] a_in,
                                                  input logic signed [31:0] b_in,
                                                  input logic [31:0] tol);
    logic signed [63:0] lo, hi, mid, f_lo, f_hi, f_mid;
    logic [63:0] m_lo, m_hi, m_mid;
    int halvings;
    bisect_out_t r;
    lo = a_in;
    hi = b_in;
    r = '{status: brf_pkg::ST_INVALID, root: '0, lower: a_in, upper: b_in, steps: '0};
    if (lo >= hi || tol == 0) return r;
    f_lo = poly_at(lo);
    if (f_lo == 0) begin
      r.status = brf_pkg::ST_EXACT;
      r.root = a_in;
      return r;
    end
    f_hi = poly_at(hi);
    if (f_hi == 0) begin
      r.status = brf_pkg::ST_EXACT;
      r.root = b_in;
      return r;
    end
    if ((f_lo < 0) == (f_hi < 0)) begin
      r.status = brf_pkg::ST_NO_CHANGE;
      return r;
    end
    halvings = 0;
    mid = lo + ((hi - lo) >>> 1);
    f_mid = poly_at(mid);
    while ($unsigned(hi - lo) > {32'd0, tol} && halvings < MAX_STEPS) begin
      // exact hit at the midpoint ends the search early
      if (f_mid == 0) begin
        r.status = brf_pkg::ST_EXACT;
        r.root = mid[31:0];
        r.lower = lo[31:0];
        r.upper = hi[31:0];
        r.steps = 6'(halvings);
        return r;
      end
      if ((f_lo < 0) == (f_mid < 0)) begin
        lo = mid;
        f_lo = f_mid;
      end else begin
        hi = mid;
        f_hi = f_mid;
      end
      halvings++;
      mid = lo + ((hi - lo) >>> 1);
      f_mid = poly_at(mid);
    end
    // best of lower, middle, upper by |f|, ties to lower then middle
    m_lo = f_lo[63] ? -f_lo : f_lo;
    m_hi = f_hi[63] ? -f_hi : f_hi;
    m_mid = f_mid[63] ? -f_mid : f_mid;
    r.status = brf_pkg::ST_BRACKET;
    r.lower = lo[31:0];
    r.upper = hi[31:0];
    r.steps = (halvings > 63) ? 6'd63 : 6'(halvings);
    if (m_lo <= m_mid && m_lo <= m_hi) r.root = lo[31:0];
    else if (m_mid <= m_lo && m_mid <= m_hi) r.root = mid[31:0];
    else r.root = hi[31:0];
    return r;
  endfunction

  // table row; a typed row carries its expectation with the ends passed through
  function automatic probe_t row(input logic signed [31:0] a, input logic signed [31:0] b,
                                 input bit typed, input logic [1:0] st,
                                 input logic signed [31:0] root);
    probe_t p;
    p.a = a;
    p.b = b;
    p.typed = typed;
    p.want = '{status: st, root: root, lower: a, upper: b, steps: '0};
    return p;
  endfunction

  // mostly back-to-back, sometimes short pauses, rarely long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 100);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      errors++;
    end
  endfunction

  // drive one interval beat and record what it should produce
  task automatic send_interval(input logic signed [31:0] a, input logic signed [31:0] b,
                               input bit typed, input bisect_out_t want);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      lower_end <= $urandom;
      upper_end <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    lower_end <= a;
    upper_end <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) pending_results.push_back(want);
    else pending_results.push_back(solve_bisection(a, b, tolerance_now));
  endtask

  // tolerance is written only once every result is back
  task automatic set_tolerance(input logic [31:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    tolerance_now = v;
  endtask

  // random interval, weighted toward ones that bracket the root
  task automatic random_interval();
    int kind, e;
    logic signed [63:0] a64, b64, t64;
    logic [63:0] span;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      // lower end below the sign change, upper end at or above it
      e = $urandom_range(1, 32);
      span = (64'd1 << e) - 64'd1;
      a64 = root_x - $signed({32'd0, $urandom} & span);
      b64 = root_x + 1 + $signed({32'd0, $urandom} & span);
      if (a64 < -64'sd2147483648) a64 = -64'sd2147483648;
      if (b64 > 64'sd2147483647) b64 = 64'sd2147483647;
    end else if (kind < 77) begin
      a64 = $signed($urandom);
      b64 = $signed($urandom);
      a64 = $signed(a64[31:0]);
      b64 = $signed(b64[31:0]);
    end else if (kind < 87) begin
      // both ends on one side of the root
      if ($urandom_range(0, 1)) begin
        a64 = $urandom_range(0, 32'h7fff_ffff);
        b64 = $urandom_range(0, 32'h7fff_ffff);
      end else begin
        a64 = -(64'sd1 <<< FRAC_BITS) - $signed({32'd0, $urandom_range(0, 32'h7000_0000)});
        b64 = -(64'sd1 <<< FRAC_BITS) - $signed({32'd0, $urandom_range(0, 32'h7000_0000)});
      end
      if (a64 > b64) begin
        t64 = a64;
        a64 = b64;
        b64 = t64;
      end
    end else if (kind < 95) begin
      // tiny interval right at the sign change
      a64 = root_x + $signed($urandom_range(0, 64)) - 32;
      b64 = a64 + $signed($urandom_range(0, 16));
    end else begin
      // empty or reversed interval
      a64 = $signed($urandom);
      a64 = $signed(a64[31:0]);
      b64 = a64 - $signed($urandom_range(0, 3));
    end
    send_interval(a64[31:0], b64[31:0], 1'b0, '0);
  endtask

  // result stall: runs of free flow, short stalls and the odd long one
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_stall <= 1'b0;
          stall_run = $urandom_range(0, 20);
        end
        9: begin
          out_stall <= 1'b1;
          stall_run = $urandom_range(10, 80);
        end
        default: begin
          out_stall <= 1'b1;
          stall_run = $urandom_range(0, 3);
        end
      endcase
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        due = pending_results.pop_front();
        check_field("status", due.status, status);
        check_field("root_estimate", due.root, root_estimate);
        check_field("final_lower", due.lower, final_lower);
        check_field("final_upper", due.upper, final_upper);
        check_field("steps_taken", due.steps, steps_taken);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("bisection_root_finder_test: errors");
      $finish;
    end
  end

  initial begin : stimulus
    probe_t probes[$];
    logic signed [63:0] neg_x, pos_x, probe_x, zero_x;
    logic signed [31:0] z;
    bit zero_found;
    logic [31:0] tol_plan[7];

    // locate the sign change of f between -1.0 and 0
    neg_x = -(64'sd1 <<< FRAC_BITS);
    pos_x = 0;
    while (pos_x - neg_x > 1) begin
      probe_x = neg_x + ((pos_x - neg_x) >>> 1);
      if (poly_at(probe_x) < 0) neg_x = probe_x;
      else pos_x = probe_x;
    end
    root_x = neg_x[31:0];
    // truncation may or may not leave an exact zero near the crossing
    zero_found = 1'b0;
    zero_x = 0;
    for (int k = -4096; k <= 4096 && !zero_found; k++) begin
      if (poly_at(neg_x + k) == 0) begin
        zero_found = 1'b1;
        zero_x = neg_x + k;
      end
    end

    // directed table, run at the reset tolerance of 1
    probes.push_back(row(32'sh0000_0000, 32'sh0000_0000, 1'b1, brf_pkg::ST_INVALID, 0));
    probes.push_back(row(32'sh7fff_ffff, 32'sh8000_0000, 1'b1, brf_pkg::ST_INVALID, 0));
    probes.push_back(row(32'sh1000_0000, 32'shf000_0000, 1'b1, brf_pkg::ST_INVALID, 0));
    probes.push_back(row(32'sh0000_0000, 32'sh7fff_ffff, 1'b1, brf_pkg::ST_NO_CHANGE, 0));
    probes.push_back(row(32'sh8000_0000, 32'shc000_0000, 1'b1, brf_pkg::ST_NO_CHANGE, 0));
    probes.push_back(row(32'sh8000_0000, 32'shf000_0000, 1'b1, brf_pkg::ST_NO_CHANGE, 0));
    probes.push_back(row(32'sh7fff_fffe, 32'sh7fff_ffff, 1'b1, brf_pkg::ST_NO_CHANGE, 0));
    probes.push_back(row(32'sh8000_0000, 32'sh8000_0001, 1'b1, brf_pkg::ST_NO_CHANGE, 0));
    probes.push_back(row(32'shf000_0000, 32'sh0000_0000, 1'b0, brf_pkg::ST_BRACKET, 0));
    probes.push_back(row(32'sh8000_0000, 32'sh7fff_ffff, 1'b0, brf_pkg::ST_BRACKET, 0));
    probes.push_back(row(32'sh8000_0001, 32'sh7fff_fffe, 1'b0, brf_pkg::ST_BRACKET, 0));
    probes.push_back(row(32'shaaaa_aaaa, 32'sh5555_5555, 1'b0, brf_pkg::ST_BRACKET, 0));
    probes.push_back(row(32'shc000_0000, 32'sh1000_0000, 1'b0, brf_pkg::ST_BRACKET, 0));
    probes.push_back(row(32'shf000_0000, 32'shf000_0001, 1'b0, brf_pkg::ST_BRACKET, 0));
    probes.push_back(row(32'shf000_0000, 32'shf000_0002, 1'b0, brf_pkg::ST_BRACKET, 0));
    probes.push_back(row(root_x, root_x + 1, 1'b0, brf_pkg::ST_BRACKET, 0));
    probes.push_back(row(root_x - 5, root_x + 7, 1'b0, brf_pkg::ST_BRACKET, 0));
    if (zero_found) begin
      // exact zero at either end, and at the first and second midpoint
      z = zero_x[31:0];
      probes.push_back(row(z, z + 32'sh1000_0000, 1'b1, brf_pkg::ST_EXACT, z));
      probes.push_back(row(z - 32'sh1000_0000, z, 1'b1, brf_pkg::ST_EXACT, z));
      probes.push_back(row(z - 32'sh0010_0000, z + 32'sh0010_0000, 1'b0, brf_pkg::ST_EXACT, 0));
      probes.push_back(row(z - 32'sh0010_0000, z + 32'sh0030_0000, 1'b0, brf_pkg::ST_EXACT, 0));
    end

    // tolerance settings for the random part, extremes included
    tol_plan[0] = 32'hffff_ffff;
    tol_plan[1] = 32'd1;
    tol_plan[2] = 32'h0001_0000;
    tol_plan[3] = $urandom_range(1, 32'hffff_ffff);
    tol_plan[4] = 32'd2;
    tol_plan[5] = 32'h8000_0000;
    tol_plan[6] = $urandom_range(1, 32'h0010_0000);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) send_interval(probes[i].a, probes[i].b, probes[i].typed, probes[i].want);

    foreach (tol_plan[p]) begin
      set_tolerance(tol_plan[p]);
      repeat (ITEMS_PER_SETTING) random_interval();
    end

    // drain, then give stray beats a chance to show up
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("bisection_root_finder_test: clean");
    end else begin
      $display("bisection_root_finder_test: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/brf_pkg.sv
rtl/bisection_root_finder.sv
tb/bisection_root_finder_test.sv
